### rtl/bb3_pkg.sv
// Shared types and constants for the 3x3 RGB box blur.
// Used by the interfaces, the column cell and the top level; depends on nothing.
package bb3_pkg;

    localparam int CHAN_W     = 8;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int WIDTH_W    = 11;
    localparam int WIN_COLS   = 3;
    localparam int COL_SUM_W  = 10;
    localparam int WIN_SUM_W  = 12;
    localparam int RECIP_W    = 13;
    localparam int PROD_W     = WIN_SUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 16;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd1024;
    localparam logic [WIDTH_W-1:0] MIN_WIDTH   = 11'd3;

    // floor(s / 9) == (s * 7282) >> 16 for every window sum up to 9 * 255.
    localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    localparam int PIX_W = $bits(pixel_t);

    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    typedef struct packed {
        logic [COL_SUM_W-1:0] blue;
        logic [COL_SUM_W-1:0] green;
        logic [COL_SUM_W-1:0] red;
    } col_sum_t;

    typedef struct packed {
        logic [WIN_SUM_W-1:0] blue;
        logic [WIN_SUM_W-1:0] green;
        logic [WIN_SUM_W-1:0] red;
    } win_sum_t;

    typedef struct packed {
        logic [PROD_W-1:0] blue;
        logic [PROD_W-1:0] green;
        logic [PROD_W-1:0] red;
    } prod_t;

endpackage

### rtl/bb3_ifs.sv
// Channel interfaces of the box blur: pixel input, filtered result output and
// the frame width write port. Depends on bb3_pkg.
interface bb3_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [bb3_pkg::CHAN_W-1:0] red_in;
    logic [bb3_pkg::CHAN_W-1:0] green_in;
    logic [bb3_pkg::CHAN_W-1:0] blue_in;
    logic                      frame_start;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output frame_start, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input frame_start, output ready);
endinterface

interface bb3_result_if;
    logic                      valid;
    logic                      ready;
    logic [bb3_pkg::CHAN_W-1:0] red_out;
    logic [bb3_pkg::CHAN_W-1:0] green_out;
    logic [bb3_pkg::CHAN_W-1:0] blue_out;
    logic [bb3_pkg::ROW_W-1:0]  center_row;
    logic [bb3_pkg::COL_W-1:0]  center_col;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output center_row, output center_col, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input center_row, input center_col, output ready);
endinterface

interface bb3_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bb3_pkg::WIDTH_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/bb3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered
// read data that updates only on a read enable. Depends on nothing.
module bb3_ram #(
    parameter  int WIDTH = 24,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bb3_col_cell.sv
// One column of the sliding 3x3 window: holds three pixels and their
// per-channel sum, and hands its column on to the next cell. Depends on bb3_pkg.
module bb3_col_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  bb3_pkg::column_t  col_in,
    output bb3_pkg::column_t  col_out,
    output bb3_pkg::col_sum_t sum_out
);

    bb3_pkg::column_t  col_reg;
    bb3_pkg::col_sum_t sum_reg;
    bb3_pkg::col_sum_t sum_next;

    always_comb
    begin
        sum_next.red   = bb3_pkg::COL_SUM_W'(col_in.top.red)
                       + bb3_pkg::COL_SUM_W'(col_in.mid.red)
                       + bb3_pkg::COL_SUM_W'(col_in.bot.red);
        sum_next.green = bb3_pkg::COL_SUM_W'(col_in.top.green)
                       + bb3_pkg::COL_SUM_W'(col_in.mid.green)
                       + bb3_pkg::COL_SUM_W'(col_in.bot.green);
        sum_next.blue  = bb3_pkg::COL_SUM_W'(col_in.top.blue)
                       + bb3_pkg::COL_SUM_W'(col_in.mid.blue)
                       + bb3_pkg::COL_SUM_W'(col_in.bot.blue);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            sum_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
            sum_reg <= sum_next;
        end
    end

    assign col_out = col_reg;
    assign sum_out = sum_reg;

endmodule

### rtl/box_blur_3x3_rgb_top.sv
// Top level of the streaming 3x3 RGB box blur.
// Depends on bb3_pkg, bb3_ifs, bb3_ram and bb3_col_cell.
//
// Pixels enter in raster order, one transaction per clock at full rate, with
// frame_start on the first pixel of a frame. Every pixel at row >= 2 and
// column >= 2 produces one result, the per-channel floor of the mean of the
// 3x3 neighborhood centered one row up and one column left, registered in the
// line store read, column cell, window sum and divide stages. The rate is set
// by the two line stores, RAMs with one read and one write port per clock, read
// at the current column and written back as the pixel leaves stage 1, and by a
// chain of three column cells that shifts once per pixel. Stalls on the result
// side back up through the pipeline; empty stages still take new pixels.
// frame_width is clamped to 3..MAX_WIDTH and should be written between frames.
module box_blur_3x3_rgb_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    bb3_cfg_if.sink      cfg,
    bb3_pixel_if.sink    pixels,
    bb3_result_if.source results
);

    localparam int AW = $clog2(MAX_WIDTH);

    // Configuration.
    logic [bb3_pkg::WIDTH_W-1:0] frame_width_reg;
    logic [bb3_pkg::WIDTH_W-1:0] width_eff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= bb3_pkg::WIDTH_RESET;
        end
        else if (cfg.valid)
        begin
            frame_width_reg <= cfg.data;
        end
    end

    always_comb
    begin
        width_eff = frame_width_reg;
        if (frame_width_reg < bb3_pkg::MIN_WIDTH)
        begin
            width_eff = bb3_pkg::MIN_WIDTH;
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            width_eff = bb3_pkg::WIDTH_W'(MAX_WIDTH);
        end
    end

    // Pipeline control.
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic s2_ready, s3_ready, s4_ready;
    logic accept, s1_adv, s2_adv, s3_adv;

    assign s4_ready     = !s4_v_reg || results.ready;
    assign s3_ready     = !s3_v_reg || s4_ready;
    assign s2_ready     = !s2_v_reg || s3_ready;
    assign pixels.ready = !s1_v_reg || s2_ready;

    assign accept = pixels.valid && pixels.ready;
    assign s1_adv = s1_v_reg && s2_ready;
    assign s2_adv = s2_v_reg && s3_ready;
    assign s3_adv = s3_v_reg && s4_ready;

    // Position counters.
    logic [bb3_pkg::COL_W-1:0]   col_reg, col_next, col_cur;
    logic [bb3_pkg::ROW_W-1:0]   row_reg, row_next, row_cur;
    logic [bb3_pkg::WIDTH_W-1:0] col_inc;
    logic                        emit_cur;

    always_comb
    begin
        col_cur  = pixels.frame_start ? '0 : col_reg;
        row_cur  = pixels.frame_start ? '0 : row_reg;
        col_inc  = bb3_pkg::WIDTH_W'(col_cur) + bb3_pkg::WIDTH_W'(1);
        emit_cur = (row_cur >= bb3_pkg::ROW_W'(2)) && (col_cur >= bb3_pkg::COL_W'(2));
        if (col_inc >= width_eff)
        begin
            col_next = '0;
            row_next = row_cur + bb3_pkg::ROW_W'(1);
        end
        else
        begin
            col_next = col_inc[bb3_pkg::COL_W-1:0];
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: line store read in flight.
    bb3_pkg::pixel_t           s1_px_reg;
    logic [AW-1:0]             s1_idx_reg;
    logic [bb3_pkg::ROW_W-1:0] s1_crow_reg;
    logic [bb3_pkg::COL_W-1:0] s1_ccol_reg;
    logic                      s1_emit_reg;
    logic                      s1_hit_reg;
    bb3_pkg::pixel_t           s1_byp_top_reg;
    bb3_pkg::pixel_t           s1_byp_mid_reg;
    logic [AW-1:0]             rd_idx;
    logic                      hit_next;
    bb3_pkg::pixel_t           px_in;
    bb3_pkg::pixel_t           older_rd, newer_rd;
    bb3_pkg::pixel_t           s1_top, s1_mid;

    assign rd_idx   = AW'(col_cur);
    assign hit_next = s1_adv && (s1_idx_reg == rd_idx);

    always_comb
    begin
        px_in.red   = pixels.red_in;
        px_in.green = pixels.green_in;
        px_in.blue  = pixels.blue_in;
    end

    // The previous pixel writes its column in the same cycle as this read, so
    // the RAM still returns old data there; forward the written values.
    assign s1_top = s1_hit_reg ? s1_byp_top_reg : older_rd;
    assign s1_mid = s1_hit_reg ? s1_byp_mid_reg : newer_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s1_emit_reg <= 1'b0;
            s1_hit_reg  <= 1'b0;
        end
        else if (accept)
        begin
            s1_v_reg    <= 1'b1;
            s1_emit_reg <= emit_cur;
            s1_hit_reg  <= hit_next;
        end
        else if (s1_adv)
        begin
            s1_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg      <= px_in;
            s1_idx_reg     <= rd_idx;
            s1_crow_reg    <= row_cur - bb3_pkg::ROW_W'(1);
            s1_ccol_reg    <= col_cur - bb3_pkg::COL_W'(1);
            s1_byp_top_reg <= s1_mid;
            s1_byp_mid_reg <= s1_px_reg;
        end
    end

    bb3_ram #(
        .WIDTH (bb3_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_line (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_idx_reg),
        .wdata (s1_mid),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (older_rd)
    );

    bb3_ram #(
        .WIDTH (bb3_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer_line (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_idx_reg),
        .wdata (s1_px_reg),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (newer_rd)
    );

    // Stage 2: chain of column cells; cell 0 holds the newest column.
    bb3_pkg::column_t          cell_link [bb3_pkg::WIN_COLS];
    bb3_pkg::col_sum_t         cell_sum  [bb3_pkg::WIN_COLS];
    logic [bb3_pkg::ROW_W-1:0] s2_crow_reg;
    logic [bb3_pkg::COL_W-1:0] s2_ccol_reg;

    always_comb
    begin
        cell_link[0].top = s1_top;
        cell_link[0].mid = s1_mid;
        cell_link[0].bot = s1_px_reg;
    end

    for (genvar k = 0; k < bb3_pkg::WIN_COLS; k++)
    begin : g_cell
        if (k < bb3_pkg::WIN_COLS - 1)
        begin : g_link
            bb3_col_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (s1_adv),
                .col_in  (cell_link[k]),
                .col_out (cell_link[k+1]),
                .sum_out (cell_sum[k])
            );
        end
        else
        begin : g_last
            bb3_col_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (s1_adv),
                .col_in  (cell_link[k]),
                .col_out (),
                .sum_out (cell_sum[k])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_v_reg <= s1_emit_reg;
        end
        else if (s2_adv)
        begin
            s2_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_crow_reg <= s1_crow_reg;
            s2_ccol_reg <= s1_ccol_reg;
        end
    end

    // Stage 3: window sum.
    bb3_pkg::win_sum_t         s3_sum_reg, s3_sum_next;
    logic [bb3_pkg::ROW_W-1:0] s3_crow_reg;
    logic [bb3_pkg::COL_W-1:0] s3_ccol_reg;

    always_comb
    begin
        s3_sum_next.red   = bb3_pkg::WIN_SUM_W'(cell_sum[0].red)
                          + bb3_pkg::WIN_SUM_W'(cell_sum[1].red)
                          + bb3_pkg::WIN_SUM_W'(cell_sum[2].red);
        s3_sum_next.green = bb3_pkg::WIN_SUM_W'(cell_sum[0].green)
                          + bb3_pkg::WIN_SUM_W'(cell_sum[1].green)
                          + bb3_pkg::WIN_SUM_W'(cell_sum[2].green);
        s3_sum_next.blue  = bb3_pkg::WIN_SUM_W'(cell_sum[0].blue)
                          + bb3_pkg::WIN_SUM_W'(cell_sum[1].blue)
                          + bb3_pkg::WIN_SUM_W'(cell_sum[2].blue);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            s3_v_reg <= 1'b1;
        end
        else if (s3_adv)
        begin
            s3_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s3_sum_reg  <= s3_sum_next;
            s3_crow_reg <= s2_crow_reg;
            s3_ccol_reg <= s2_ccol_reg;
        end
    end

    // Stage 4: divide by nine through a reciprocal multiply; this is the
    // output register.
    bb3_pkg::prod_t            s4_prod_reg, s4_prod_next;
    logic [bb3_pkg::ROW_W-1:0] s4_crow_reg;
    logic [bb3_pkg::COL_W-1:0] s4_ccol_reg;

    always_comb
    begin
        s4_prod_next.red   = bb3_pkg::PROD_W'(s3_sum_reg.red)
                           * bb3_pkg::PROD_W'(bb3_pkg::RECIP_9);
        s4_prod_next.green = bb3_pkg::PROD_W'(s3_sum_reg.green)
                           * bb3_pkg::PROD_W'(bb3_pkg::RECIP_9);
        s4_prod_next.blue  = bb3_pkg::PROD_W'(s3_sum_reg.blue)
                           * bb3_pkg::PROD_W'(bb3_pkg::RECIP_9);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (s3_adv)
        begin
            s4_v_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            s4_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            s4_prod_reg <= s4_prod_next;
            s4_crow_reg <= s3_crow_reg;
            s4_ccol_reg <= s3_ccol_reg;
        end
    end

    assign results.valid      = s4_v_reg;
    assign results.red_out    = s4_prod_reg.red[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
    assign results.green_out  = s4_prod_reg.green[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
    assign results.blue_out   = s4_prod_reg.blue[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
    assign results.center_row = s4_crow_reg;
    assign results.center_col = s4_ccol_reg;

`ifndef SYNTHESIS
    // Forwarding is only armed when the previous pixel wrote the line stores.
    a_hit_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        accept && hit_next |=> s1_hit_reg && $past(s1_adv))
        else $error("line store forward armed without a write");

    // An interior pixel leaving stage 1 must show up as a valid window.
    a_emit_to_window: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_emit_reg |=> s2_v_reg)
        else $error("interior pixel lost in the column cells");

    // An empty pipeline always takes a pixel.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_v_reg && !s2_v_reg && !s3_v_reg && !s4_v_reg |-> pixels.ready)
        else $error("empty pipeline refused a pixel");

    // Results never sit on the frame border.
    a_no_border: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.center_row != '0) && (results.center_col != '0))
        else $error("result centered on the frame border");
`endif

endmodule

### test/tb_box_blur_3x3_rgb_top.sv
// Self-checking testbench for the 3x3 RGB box blur top level.
// Drives pixels and frame width writes, predicts every filtered pixel and checks each result.
// Depends on bb3_pkg, bb3_ifs and box_blur_3x3_rgb_top.
module tb_box_blur_3x3_rgb_top;

    localparam int CLK_PERIOD    = 12;
    localparam int LINE_DEPTH    = 1024;
    localparam int WINDOW_PIXELS = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 80;
    localparam int RANDOM_ITEMS  = 290;

    typedef struct packed {
        logic [bb3_pkg::CHAN_W-1:0] red;
        logic [bb3_pkg::CHAN_W-1:0] green;
        logic [bb3_pkg::CHAN_W-1:0] blue;
        logic [bb3_pkg::ROW_W-1:0]  row;
        logic [bb3_pkg::COL_W-1:0]  col;
    } blur_result_t;

    logic clk;
    logic rst_n;

    bb3_cfg_if    cfg_if ();
    bb3_pixel_if  pix_if ();
    bb3_result_if res_if ();

    box_blur_3x3_rgb_top #(
        .MAX_WIDTH(LINE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_if),
        .pixels(pix_if),
        .results(res_if)
    );

    // Predicted state of the filter.
    bb3_pkg::pixel_t             older_px [LINE_DEPTH];
    bb3_pkg::pixel_t             newer_px [LINE_DEPTH];
    bb3_pkg::pixel_t             win_px [6];
    logic [bb3_pkg::COL_W-1:0]   next_col;
    logic [bb3_pkg::ROW_W-1:0]   next_row;
    logic [bb3_pkg::WIDTH_W-1:0] width_reg;

    blur_result_t pending_blurs[$];
    int           mismatch_count = 0;
    bit           idling_on = 1'b1;
    int           long_hold = 0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * 1_500_000);
        $display("TEST FAILED");
        $finish;
    end

    // Works out the filtered pixel, if any, caused by one accepted input pixel.
    task automatic compute_blur(input bb3_pkg::pixel_t px, input logic fs);
        int              w;
        int              c;
        int              r;
        int              sum_r;
        int              sum_g;
        int              sum_b;
        bb3_pkg::pixel_t top;
        bb3_pkg::pixel_t mid;
        bb3_pkg::pixel_t nb [WINDOW_PIXELS];
        blur_result_t    res;
        w = int'(width_reg);
        if (w < int'(bb3_pkg::MIN_WIDTH))
            w = int'(bb3_pkg::MIN_WIDTH);
        if (w > LINE_DEPTH)
            w = LINE_DEPTH;
        if (fs)
        begin
            next_col = '0;
            next_row = '0;
        end
        c = int'(next_col);
        r = int'(next_row);
        top = older_px[c];
        mid = newer_px[c];
        if (r >= 2 && c >= 2)
        begin
            for (int i = 0; i < 6; i++)
                nb[i] = win_px[i];
            nb[6] = top;
            nb[7] = mid;
            nb[8] = px;
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (int i = 0; i < WINDOW_PIXELS; i++)
            begin
                sum_r += nb[i].red;
                sum_g += nb[i].green;
                sum_b += nb[i].blue;
            end
            res.red   = bb3_pkg::CHAN_W'(sum_r / WINDOW_PIXELS);
            res.green = bb3_pkg::CHAN_W'(sum_g / WINDOW_PIXELS);
            res.blue  = bb3_pkg::CHAN_W'(sum_b / WINDOW_PIXELS);
            res.row   = bb3_pkg::ROW_W'(r - 1);
            res.col   = bb3_pkg::COL_W'(c - 1);
            pending_blurs.push_back(res);
        end
        for (int i = 0; i < 3; i++)
            win_px[i] = win_px[i + 3];
        win_px[3] = top;
        win_px[4] = mid;
        win_px[5] = px;
        older_px[c] = mid;
        newer_px[c] = px;
        if (c + 1 >= w)
        begin
            next_col = '0;
            next_row = bb3_pkg::ROW_W'(r + 1);
        end
        else
            next_col = bb3_pkg::COL_W'(c + 1);
    endtask

    function automatic logic [bb3_pkg::CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return bb3_pkg::CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic bb3_pkg::pixel_t rand_pixel();
        bb3_pkg::pixel_t p;
        p.red   = rand_chan();
        p.green = rand_chan();
        p.blue  = rand_chan();
        return p;
    endfunction

    // Offers one pixel and returns at the edge where its transaction completes.
    // Valid stays high afterwards so back-to-back pixels need no gap.
    task automatic send_pixel(input bb3_pkg::pixel_t px, input logic fs);
        @(negedge clk);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.red_in      <= px.red;
        pix_if.green_in    <= px.green;
        pix_if.blue_in     <= px.blue;
        pix_if.frame_start <= fs;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        compute_blur(px, fs);
    endtask

    task automatic send_random(input int count, input bit start);
        for (int i = 0; i < count; i++)
            send_pixel(rand_pixel(), start && i == 0);
    endtask

    // Lets the pipeline empty out so that the width register may be written.
    task automatic drain_pipeline();
        @(negedge clk);
        pix_if.valid <= 1'b0;
        while (pending_blurs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [bb3_pkg::WIDTH_W-1:0] w);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= w;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        width_reg = w;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: random bursts of back-pressure plus the long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                res_if.ready <= 1'b0;
                long_hold--;
            end
            else if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 14);
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    initial
    begin
        blur_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
            begin
                if (pending_blurs.size() == 0)
                begin
                    $error("result at row %0d col %0d with no prediction waiting",
                           res_if.center_row, res_if.center_col);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_blurs.pop_front();
                    compare_field("red_out", 32'(want.red), 32'(res_if.red_out));
                    compare_field("green_out", 32'(want.green), 32'(res_if.green_out));
                    compare_field("blue_out", 32'(want.blue), 32'(res_if.blue_out));
                    compare_field("center_row", 32'(want.row), 32'(res_if.center_row));
                    compare_field("center_col", 32'(want.col), 32'(res_if.center_col));
                end
            end
        end
    end

    // The width left by reset is so wide that a short frame gives no result.
    task automatic test_reset_width();
        send_random(40, 1'b1);
    endtask

    // Saturated windows, single-channel extremes and a restart mid-frame.
    task automatic test_extremes();
        bb3_pkg::pixel_t white;
        bb3_pkg::pixel_t black;
        bb3_pkg::pixel_t mixed;
        white = '1;
        black = '0;
        mixed.red   = 8'hFF;
        mixed.green = 8'h00;
        mixed.blue  = 8'h80;
        drain_pipeline();
        write_width(bb3_pkg::MIN_WIDTH);
        for (int i = 0; i < 9; i++)
            send_pixel(white, i == 0);
        for (int i = 0; i < 3; i++)
            send_pixel(black, 1'b0);
        for (int i = 0; i < 3; i++)
            send_pixel(mixed, 1'b0);
        send_pixel(white, 1'b0);
        send_pixel(black, 1'b1);
        send_pixel(black, 1'b0);
    endtask

    // Widths below the minimum and above the line store depth are clamped.
    task automatic test_width_clamp();
        drain_pipeline();
        write_width('0);
        send_random(12, 1'b1);
        drain_pipeline();
        write_width(11'd2);
        send_random(10, 1'b1);
        drain_pipeline();
        write_width('1);
        send_random(30, 1'b1);
    endtask

    // The width shrinks inside a frame, once ahead of the column and once behind it.
    task automatic test_mid_frame_shrink();
        drain_pipeline();
        write_width(11'd8);
        send_random(19, 1'b1);
        drain_pipeline();
        write_width(11'd6);
        send_random(14, 1'b0);
        drain_pipeline();
        write_width(11'd4);
        send_random(8, 1'b0);
    endtask

    // The result side holds off long enough for the pipeline to fill and stall the input.
    task automatic test_backpressure();
        drain_pipeline();
        write_width(11'd5);
        long_hold = LONG_HOLD;
        send_random(70, 1'b1);
    endtask

    // Random frames of random size, some cut short, some restarted part way through.
    task automatic test_random_frames();
        int sent;
        int w;
        int eff_w;
        int n;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain_pipeline();
            idling_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: w = $urandom_range(0, 2);
                1: w = $urandom_range(17, 64);
                default: w = $urandom_range(3, 16);
            endcase
            write_width(bb3_pkg::WIDTH_W'(w));
            eff_w = (w < 3) ? 3 : w;
            n = eff_w * $urandom_range(3, 8);
            if ($urandom_range(0, 7) == 0)
                n = $urandom_range(1, n);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            for (int i = 0; i < n; i++)
                send_pixel(rand_pixel(), i == 0 || $urandom_range(0, 79) == 0);
            sent += n;
        end
        idling_on = 1'b1;
    endtask

    // The closing stretch runs at full rate on both sides.
    task automatic test_full_rate();
        drain_pipeline();
        idling_on = 1'b0;
        write_width(11'd4);
        send_random(40, 1'b1);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        pix_if.valid       = 1'b0;
        pix_if.red_in      = '0;
        pix_if.green_in    = '0;
        pix_if.blue_in     = '0;
        pix_if.frame_start = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        foreach (older_px[i])
        begin
            older_px[i] = '0;
            newer_px[i] = '0;
        end
        foreach (win_px[i])
            win_px[i] = '0;
        next_col  = '0;
        next_row  = '0;
        width_reg = bb3_pkg::WIDTH_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_width();
        test_extremes();
        test_width_clamp();
        test_mid_frame_shrink();
        test_backpressure();
        test_random_frames();
        test_full_rate();

        drain_pipeline();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### box_blur_3x3_rgb_top.f
rtl/bb3_pkg.sv
rtl/bb3_ifs.sv
rtl/bb3_ram.sv
rtl/bb3_col_cell.sv
rtl/box_blur_3x3_rgb_top.sv
test/tb_box_blur_3x3_rgb_top.sv
